// ===== sv/pite_pkg.sv =====
// Shared constants for the point-in-triangle edge test pipeline.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pite_pkg;

   localparam int COORD_BITS_DEF = 16;

   localparam int NUM_AXES  = 3;
   localparam int NUM_PTS   = 4;
   localparam int NUM_CROSS = 4;
   localparam int NUM_EDGES = 3;

   localparam int AX_X = 0;
   localparam int AX_Y = 1;
   localparam int AX_Z = 2;

   localparam int PT_A = 0;
   localparam int PT_B = 1;
   localparam int PT_C = 2;
   localparam int PT_P = 3;

   // Cross product slot 0 is the triangle normal, slots 1..3 the edges.
   localparam int CR_NORMAL = 0;
   localparam int CR_AB     = 1;
   localparam int CR_BC     = 2;
   localparam int CR_CA     = 3;

endpackage

`default_nettype wire

// ===== sv/pite_diff.sv =====
// Stage 1: edge and point-offset difference vectors for all cross products.
// Depends on pite_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pite_diff
   import pite_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         valid_in,
   input  wire logic signed [COORD_BITS-1:0] pts [NUM_PTS][NUM_AXES],
   output logic                              valid_ff,
   output logic signed [COORD_BITS:0]        u_ff [NUM_CROSS][NUM_AXES],
   output logic signed [COORD_BITS:0]        v_ff [NUM_CROSS][NUM_AXES]
);

   localparam int DW = COORD_BITS + 1;

   logic signed [DW-1:0] u_in [NUM_CROSS][NUM_AXES];
   logic signed [DW-1:0] v_in [NUM_CROSS][NUM_AXES];

   always_comb begin
      for (int j = 0; j < NUM_AXES; j++) begin
         u_in[CR_NORMAL][j] = DW'(pts[PT_B][j]) - DW'(pts[PT_A][j]);
         v_in[CR_NORMAL][j] = DW'(pts[PT_C][j]) - DW'(pts[PT_A][j]);
         u_in[CR_AB][j]     = DW'(pts[PT_B][j]) - DW'(pts[PT_A][j]);
         v_in[CR_AB][j]     = DW'(pts[PT_P][j]) - DW'(pts[PT_A][j]);
         u_in[CR_BC][j]     = DW'(pts[PT_C][j]) - DW'(pts[PT_B][j]);
         v_in[CR_BC][j]     = DW'(pts[PT_P][j]) - DW'(pts[PT_B][j]);
         u_in[CR_CA][j]     = DW'(pts[PT_A][j]) - DW'(pts[PT_C][j]);
         v_in[CR_CA][j]     = DW'(pts[PT_P][j]) - DW'(pts[PT_C][j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff <= u_in;
         v_ff <= v_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/pite_cross.sv =====
// Stages 2-3: cross products of the difference vectors (multiply, then subtract).
// Depends on pite_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pite_cross
   import pite_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         valid_in,
   input  wire logic signed [COORD_BITS:0]   u [NUM_CROSS][NUM_AXES],
   input  wire logic signed [COORD_BITS:0]   v [NUM_CROSS][NUM_AXES],
   output logic                              valid_ff,
   output logic signed [2*COORD_BITS+2:0]    x_ff [NUM_CROSS][NUM_AXES]
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int XW = PW + 1;

   // per component: positive term and negative term
   logic signed [PW-1:0] pos_in [NUM_CROSS][NUM_AXES];
   logic signed [PW-1:0] neg_in [NUM_CROSS][NUM_AXES];
   logic signed [PW-1:0] pos_ff [NUM_CROSS][NUM_AXES];
   logic signed [PW-1:0] neg_ff [NUM_CROSS][NUM_AXES];
   logic signed [XW-1:0] x_in   [NUM_CROSS][NUM_AXES];
   logic                 mul_valid_ff;

   always_comb begin
      for (int k = 0; k < NUM_CROSS; k++) begin
         pos_in[k][AX_X] = u[k][AX_Y] * v[k][AX_Z];
         neg_in[k][AX_X] = u[k][AX_Z] * v[k][AX_Y];
         pos_in[k][AX_Y] = u[k][AX_Z] * v[k][AX_X];
         neg_in[k][AX_Y] = u[k][AX_X] * v[k][AX_Z];
         pos_in[k][AX_Z] = u[k][AX_X] * v[k][AX_Y];
         neg_in[k][AX_Z] = u[k][AX_Y] * v[k][AX_X];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CROSS; k++) begin
         for (int j = 0; j < NUM_AXES; j++) begin
            x_in[k][j] = XW'(pos_ff[k][j]) - XW'(neg_ff[k][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (adv) begin
         mul_valid_ff <= valid_in;
         valid_ff     <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff <= pos_in;
         neg_ff <= neg_in;
         x_ff   <= x_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/pite_dot.sv =====
// Stages 4-6: dot products of the edge cross products with the normal and
// the final sign test. Wide products are split into four partial products.
// Depends on pite_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pite_dot
   import pite_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         valid_in,
   input  wire logic signed [2*COORD_BITS+2:0] x [NUM_CROSS][NUM_AXES],
   output logic                              valid_ff,
   output logic                              inside_ff
);

   localparam int XW  = 2 * COORD_BITS + 3;
   localparam int LO  = XW / 2;
   localparam int HI  = XW - LO;
   localparam int HHW = 2 * HI;
   localparam int HLW = HI + LO + 1;
   localparam int LLW = 2 * LO;
   localparam int TW  = 2 * XW;
   localparam int SW  = TW + 2;

   logic signed [HHW-1:0] hh_in [NUM_EDGES][NUM_AXES];
   logic signed [HLW-1:0] hl_in [NUM_EDGES][NUM_AXES];
   logic signed [HLW-1:0] lh_in [NUM_EDGES][NUM_AXES];
   logic        [LLW-1:0] ll_in [NUM_EDGES][NUM_AXES];
   logic signed [HHW-1:0] hh_ff [NUM_EDGES][NUM_AXES];
   logic signed [HLW-1:0] hl_ff [NUM_EDGES][NUM_AXES];
   logic signed [HLW-1:0] lh_ff [NUM_EDGES][NUM_AXES];
   logic        [LLW-1:0] ll_ff [NUM_EDGES][NUM_AXES];
   logic signed [TW-1:0]  term_in [NUM_EDGES][NUM_AXES];
   logic signed [TW-1:0]  term_ff [NUM_EDGES][NUM_AXES];
   logic signed [SW-1:0]  sum     [NUM_EDGES];
   logic                  inside_in;
   logic                  pp_valid_ff;
   logic                  term_valid_ff;

   always_comb begin
      logic signed [HI-1:0] e_hi;
      logic signed [LO:0]   e_lo;
      logic signed [HI-1:0] n_hi;
      logic signed [LO:0]   n_lo;
      for (int e = 0; e < NUM_EDGES; e++) begin
         for (int j = 0; j < NUM_AXES; j++) begin
            e_hi = x[e+1][j][XW-1:LO];
            e_lo = $signed({1'b0, x[e+1][j][LO-1:0]});
            n_hi = x[CR_NORMAL][j][XW-1:LO];
            n_lo = $signed({1'b0, x[CR_NORMAL][j][LO-1:0]});
            hh_in[e][j] = HHW'(e_hi) * HHW'(n_hi);
            hl_in[e][j] = HLW'(e_hi) * HLW'(n_lo);
            lh_in[e][j] = HLW'(e_lo) * HLW'(n_hi);
            ll_in[e][j] = LLW'(x[e+1][j][LO-1:0]) * LLW'(x[CR_NORMAL][j][LO-1:0]);
         end
      end
   end

   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         for (int j = 0; j < NUM_AXES; j++) begin
            term_in[e][j] = (TW'(hh_ff[e][j]) <<< (2 * LO))
                          + (TW'(hl_ff[e][j]) <<< LO)
                          + (TW'(lh_ff[e][j]) <<< LO)
                          + TW'($signed({1'b0, ll_ff[e][j]}));
         end
      end
   end

   always_comb begin
      inside_in = 1'b1;
      for (int e = 0; e < NUM_EDGES; e++) begin
         sum[e] = SW'(term_ff[e][AX_X]) + SW'(term_ff[e][AX_Y]) + SW'(term_ff[e][AX_Z]);
         if (sum[e][SW-1]) begin
            inside_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff   <= 1'b0;
         term_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else if (adv) begin
         pp_valid_ff   <= valid_in;
         term_valid_ff <= pp_valid_ff;
         valid_ff      <= term_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hh_ff     <= hh_in;
         hl_ff     <= hl_in;
         lh_ff     <= lh_in;
         ll_ff     <= ll_in;
         term_ff   <= term_in;
         inside_ff <= inside_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/point_in_triangle_edge_test.sv =====
// Point-in-triangle edge cross product test, six-stage pipeline.
// Throughput: one item per cycle while no result waits under rsp_stall.
// The whole pipeline holds while a result waits under rsp_stall; req_stall follows.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
// Depends on pite_pkg, pite_diff, pite_cross, pite_dot.
`timescale 1ns / 1ps
`default_nettype none

module point_in_triangle_edge_test
   import pite_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_a_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_y,
   input  wire logic signed [COORD_BITS-1:0] req_a_z,
   input  wire logic signed [COORD_BITS-1:0] req_b_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_z,
   input  wire logic signed [COORD_BITS-1:0] req_c_x,
   input  wire logic signed [COORD_BITS-1:0] req_c_y,
   input  wire logic signed [COORD_BITS-1:0] req_c_z,
   input  wire logic signed [COORD_BITS-1:0] req_p_x,
   input  wire logic signed [COORD_BITS-1:0] req_p_y,
   input  wire logic signed [COORD_BITS-1:0] req_p_z,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_inside_res
);

   logic                         adv;
   logic signed [COORD_BITS-1:0] pts [NUM_PTS][NUM_AXES];
   logic                         diff_valid;
   logic signed [COORD_BITS:0]   u [NUM_CROSS][NUM_AXES];
   logic signed [COORD_BITS:0]   v [NUM_CROSS][NUM_AXES];
   logic                         cross_valid;
   logic signed [2*COORD_BITS+2:0] x [NUM_CROSS][NUM_AXES];

   // hold every stage while the output item is stalled
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      pts[PT_A][AX_X] = req_a_x;
      pts[PT_A][AX_Y] = req_a_y;
      pts[PT_A][AX_Z] = req_a_z;
      pts[PT_B][AX_X] = req_b_x;
      pts[PT_B][AX_Y] = req_b_y;
      pts[PT_B][AX_Z] = req_b_z;
      pts[PT_C][AX_X] = req_c_x;
      pts[PT_C][AX_Y] = req_c_y;
      pts[PT_C][AX_Z] = req_c_z;
      pts[PT_P][AX_X] = req_p_x;
      pts[PT_P][AX_Y] = req_p_y;
      pts[PT_P][AX_Z] = req_p_z;
   end

   pite_diff #(
      .COORD_BITS (COORD_BITS)
   ) u_diff (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .valid_in (req_valid),
      .pts      (pts),
      .valid_ff (diff_valid),
      .u_ff     (u),
      .v_ff     (v)
   );

   pite_cross #(
      .COORD_BITS (COORD_BITS)
   ) u_cross (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .valid_in (diff_valid),
      .u        (u),
      .v        (v),
      .valid_ff (cross_valid),
      .x_ff     (x)
   );

   pite_dot #(
      .COORD_BITS (COORD_BITS)
   ) u_dot (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_in  (cross_valid),
      .x         (x),
      .valid_ff  (rsp_valid),
      .inside_ff (rsp_inside_res)
   );

endmodule

`default_nettype wire
